// File: sv/arpe_pkg.sv
`default_nettype none
package arpe_pkg;
   localparam int KeySlotsDefault = 15;
   localparam int BlockLen = 16;
   localparam logic [63:0] MixHiReset = 64'h0203010101020301;
   localparam logic [63:0] MixLoReset = 64'h0101020303010102;

   localparam logic [2:0] CMD_LOAD_STATE = 3'd0;
   localparam logic [2:0] CMD_LOAD_TABLE = 3'd1;
   localparam logic [2:0] CMD_LOAD_KEY   = 3'd2;
   localparam logic [2:0] CMD_ADDKEY     = 3'd3;
   localparam logic [2:0] CMD_SUBBYTES   = 3'd4;
   localparam logic [2:0] CMD_SHIFT      = 3'd5;
   localparam logic [2:0] CMD_INVSHIFT   = 3'd6;
   localparam logic [2:0] CMD_MIX        = 3'd7;

   localparam logic CSR_MIX_HI = 1'b0;
   localparam logic CSR_MIX_LO = 1'b1;

   typedef struct packed {
      logic [2:0]   command;
      logic [3:0]   key_slot;
      logic [7:0]   table_index;
      logic [63:0]  data_high;
      logic [63:0]  data_low;
   } cmd_type;

   localparam int CmdBits = $bits(cmd_type);

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] a;
      logic [7:0] p;
      a = x;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (y[i]) p = p ^ a;
         a = xtime(a);
      end
      gf_mul = p;
   endfunction
endpackage
`default_nettype wire

// File: sv/arpe_front.sv
`default_nettype none
module arpe_front
   import arpe_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire cmd_type            in_cmd,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output cmd_type                 out_cmd
);
   // two-entry queue
   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = q_ff[0];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if ((cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop)) q_in[0] = in_cmd;
         else q_in[1] = in_cmd;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// File: sv/arpe_back.sv
`default_nettype none
module arpe_back
   import arpe_pkg::*;
#(
   parameter int KEY_SLOTS = KeySlotsDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire cmd_type       in_cmd,
   input  wire logic [63:0]   mix_hi,
   input  wire logic [63:0]   mix_lo,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [127:0]       out_state
);
   localparam int SlotBits = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   logic [7:0]   sbox_mem [256];
   logic [127:0] key_mem [KEY_SLOTS];
   logic [127:0] state_ff, state_in;
   logic         valid_ff;
   logic         take;
   logic         out_free;
   logic         sub_start;
   logic         sub_done;
   logic         sub_busy_ff;
   logic [3:0]   sub_cnt_ff;
   logic         rd_valid_ff;
   logic [2:0]   rd_pair_ff;
   logic [7:0]   rd0_ff, rd1_ff;
   logic [7:0]   rd_addr0, rd_addr1;
   logic [127:0] sub_ff, sub_in;
   logic [127:0] mix_all;
   logic [127:0] load_word;
   logic [7:0]   b [BlockLen];
   logic [7:0]   nb [BlockLen];
   logic [7:0]   mb [BlockLen];
   logic [127:0] key_word;
   logic         slot_ok;
   logic [SlotBits-1:0] slot;

   assign out_free  = !valid_ff || out_ready;
   assign in_ready  = !sub_busy_ff && out_free;
   assign take      = in_valid && in_ready;
   assign sub_start = take && (in_cmd.command == CMD_SUBBYTES);
   assign sub_done  = sub_busy_ff && (sub_cnt_ff == 4'd8) && out_free;
   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign slot_ok   = ({28'd0, in_cmd.key_slot} < KEY_SLOTS);
   assign slot      = in_cmd.key_slot[SlotBits-1:0];
   assign key_word  = key_mem[slot];
   assign mix_all   = {mix_hi, mix_lo};
   assign load_word = {in_cmd.data_high, in_cmd.data_low};
   // subbytes looks up two state bytes per cycle
   assign rd_addr0  = b[{sub_cnt_ff[2:0], 1'b0}];
   assign rd_addr1  = b[{sub_cnt_ff[2:0], 1'b1}];

   always_comb begin
      sub_in = sub_ff;
      if (rd_valid_ff) begin
         sub_in[127-16*rd_pair_ff -: 16] = {rd0_ff, rd1_ff};
      end
   end

   always_comb begin
      for (int i = 0; i < BlockLen; i++) begin
         b[i] = state_ff[127-8*i -: 8];
         mb[i] = mix_all[127-8*i -: 8];
      end
      for (int i = 0; i < BlockLen; i++) nb[i] = b[i];
      unique case (in_cmd.command)
         CMD_LOAD_STATE: begin
            for (int i = 0; i < BlockLen; i++)
               nb[i] = load_word[127-8*i -: 8];
         end
         CMD_ADDKEY: begin
            if (slot_ok)
               for (int i = 0; i < BlockLen; i++)
                  nb[i] = b[i] ^ key_word[127-8*i -: 8];
         end
         CMD_SHIFT: begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  nb[r+4*c] = b[r+4*((c+r)%4)];
         end
         CMD_INVSHIFT: begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  nb[r+4*c] = b[r+4*((c+4-r)%4)];
         end
         CMD_MIX: begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  nb[4*c+r] = gf_mul(b[4*c], mb[4*r]) ^ gf_mul(b[4*c+1], mb[4*r+1])
                            ^ gf_mul(b[4*c+2], mb[4*r+2]) ^ gf_mul(b[4*c+3], mb[4*r+3]);
         end
         default: begin
         end
      endcase
      for (int i = 0; i < BlockLen; i++) state_in[127-8*i -: 8] = nb[i];
   end

   always_ff @(posedge clock) begin
      if (take && in_cmd.command == CMD_LOAD_TABLE)
         sbox_mem[in_cmd.table_index] <= in_cmd.data_low[7:0];
      if (sub_busy_ff && !sub_cnt_ff[3]) begin
         rd0_ff <= sbox_mem[rd_addr0];
         rd1_ff <= sbox_mem[rd_addr1];
      end
      if (take && in_cmd.command == CMD_LOAD_KEY && slot_ok)
         key_mem[slot] <= {in_cmd.data_high, in_cmd.data_low};
   end

   always_ff @(posedge clock) begin
      sub_ff <= sub_in;
      if (reset) begin
         state_ff    <= '0;
         valid_ff    <= 1'b0;
         sub_busy_ff <= 1'b0;
         sub_cnt_ff  <= 4'd0;
         rd_valid_ff <= 1'b0;
         rd_pair_ff  <= 3'd0;
      end else begin
         if (take && !sub_start) state_ff <= state_in;
         else if (sub_done) state_ff <= sub_in;
         if ((take && !sub_start) || sub_done) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
         rd_valid_ff <= sub_busy_ff && !sub_cnt_ff[3];
         rd_pair_ff  <= sub_cnt_ff[2:0];
         if (sub_start) begin
            sub_busy_ff <= 1'b1;
            sub_cnt_ff  <= 4'd0;
         end else if (sub_done) begin
            sub_busy_ff <= 1'b0;
         end else if (sub_busy_ff && !sub_cnt_ff[3]) begin
            sub_cnt_ff <= sub_cnt_ff + 4'd1;
         end
      end
   end
endmodule
`default_nettype wire

// File: sv/aes_round_primitive_engine.sv
`default_nettype none
// channel | dir | fields (low bit up)
// req     | in  | tdata: command, key_slot, table_index, data_high, data_low
// rsp     | out | tdata: state_high, state_low
// csr     | in  | index 0 mix_matrix_hi, 1 mix_matrix_lo
// One word per cycle while neither rsp nor a busy back end stalls; a word is registered
// in the two-entry command queue and then in the back end's state register before rsp.
// Subbytes reads the table two bytes per cycle and keeps the back end busy until it is done.
// Synchronous reset clears state and queue and resets the matrix; table and keys are not cleared.
// Stalls on rsp or a busy back end fill the queue before req_tready drops.
module aes_round_primitive_engine
   import arpe_pkg::*;
#(
   parameter int KEY_SLOTS = KeySlotsDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [143:0]  req_tdata,  // command, key_slot, table_index, data_high, data_low
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata,  // state_high, state_low
   input  wire logic          csr_we,
   input  wire logic          csr_index,
   input  wire logic [63:0]   csr_wdata
);
   cmd_type      in_cmd, q_cmd;
   logic         q_valid, q_ready;
   logic [63:0]  mix_hi_ff, mix_lo_ff;
   logic [127:0] st;

   assign in_cmd.command     = req_tdata[2:0];
   assign in_cmd.key_slot    = req_tdata[6:3];
   assign in_cmd.table_index = req_tdata[14:7];
   assign in_cmd.data_high   = req_tdata[78:15];
   assign in_cmd.data_low    = req_tdata[142:79];
   assign rsp_tdata = {st[63:0], st[127:64]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_hi_ff <= MixHiReset;
         mix_lo_ff <= MixLoReset;
      end else if (csr_we) begin
         if (csr_index == CSR_MIX_HI) mix_hi_ff <= csr_wdata;
         else mix_lo_ff <= csr_wdata;
      end
   end

   arpe_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   arpe_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_cmd(q_cmd),
      .mix_hi(mix_hi_ff), .mix_lo(mix_lo_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_state(st)
   );
endmodule
`default_nettype wire

// File: bench/aes_round_checker.sv
`timescale 1ns / 100ps
module aes_round_checker
   import arpe_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   input  wire logic          req_tready,
   input  wire logic [143:0]  req_tdata,  // command, key_slot, table_index, data_high, data_low
   input  wire logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire logic [127:0]  rsp_tdata,  // state_high, state_low
   input  wire logic          csr_we,
   input  wire logic          csr_index,
   input  wire logic [63:0]   csr_wdata,
   output int                 error_count,
   output int                 pending
);
   localparam int NumSlots = KeySlotsDefault;

   logic [63:0]  mix_hi;
   logic [63:0]  mix_lo;
   logic [7:0]   aes_state [BlockLen];
   logic [7:0]   sbox [256];
   logic [127:0] round_keys [NumSlots];
   logic [127:0] expected_states [$];

   initial error_count = 0;
   assign pending = expected_states.size();

   function automatic logic [7:0] gmul(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] a;
      logic [7:0] p;
      a = x;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (y[i]) p = p ^ a;
         a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      end
      return p;
   endfunction

   function automatic logic [127:0] apply_primitive(input logic [143:0] w);
      logic [2:0]   cmd;
      logic [3:0]   slot;
      logic [7:0]   tidx;
      logic [127:0] data;
      logic [127:0] mat;
      logic [7:0]   t [BlockLen];
      logic [7:0]   acc;
      logic [127:0] packed_state;
      cmd  = w[2:0];
      slot = w[6:3];
      tidx = w[14:7];
      data = {w[78:15], w[142:79]};
      mat  = {mix_hi, mix_lo};
      for (int k = 0; k < BlockLen; k++) t[k] = aes_state[k];
      case (cmd) inside
         CMD_LOAD_STATE: begin
            for (int k = 0; k < BlockLen; k++) aes_state[k] = data[127-8*k -: 8];
         end
         CMD_LOAD_TABLE: sbox[tidx] = data[7:0];
         CMD_LOAD_KEY: begin
            if (slot < NumSlots) round_keys[slot] = data;
         end
         CMD_ADDKEY: begin
            if (slot < NumSlots)
               for (int k = 0; k < BlockLen; k++)
                  aes_state[k] = t[k] ^ round_keys[slot][127-8*k -: 8];
         end
         CMD_SUBBYTES: begin
            for (int k = 0; k < BlockLen; k++) aes_state[k] = sbox[t[k]];
         end
         CMD_SHIFT, CMD_INVSHIFT: begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  aes_state[r+4*c] = (cmd == CMD_SHIFT) ? t[r+4*((c+r)&3)]
                                                        : t[r+4*((c+4-r)&3)];
         end
         default: begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) begin
                  acc = 8'h00;
                  for (int i = 0; i < 4; i++)
                     acc = acc ^ gmul(t[4*c+i], mat[127-8*(4*r+i) -: 8]);
                  aes_state[4*c+r] = acc;
               end
         end
      endcase
      for (int k = 0; k < BlockLen; k++) packed_state[127-8*k -: 8] = aes_state[k];
      return packed_state;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mix_hi <= MixHiReset;
         mix_lo <= MixLoReset;
         for (int k = 0; k < BlockLen; k++) aes_state[k] = 8'h00;
         expected_states.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MIX_HI) mix_hi <= csr_wdata;
            else mix_lo <= csr_wdata;
         end
         if (req_tvalid && req_tready)
            expected_states.push_back(apply_primitive(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_states.size() == 0) begin
               $error("unexpected rsp word %h", rsp_tdata);
               error_count++;
            end else begin
               // rsp tdata carries state_low above state_high
               if (rsp_tdata[63:0] !== expected_states[0][127:64]) begin
                  $error("state_high expected %h actual %h",
                         expected_states[0][127:64], rsp_tdata[63:0]);
                  error_count++;
               end
               if (rsp_tdata[127:64] !== expected_states[0][63:0]) begin
                  $error("state_low expected %h actual %h",
                         expected_states[0][63:0], rsp_tdata[127:64]);
                  error_count++;
               end
               void'(expected_states.pop_front());
            end
         end
      end
   end
endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
module tb;
   import arpe_pkg::*;

   localparam int StallLimit = 2000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [143:0]  req_tdata = '0;  // command, key_slot, table_index, data_high, data_low
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;       // state_high, state_low
   logic          csr_we = 1'b0;
   logic          csr_index = CSR_MIX_HI;
   logic [63:0]   csr_wdata = '0;
   logic          no_idle = 1'b0;
   int            error_count;
   int            pending;
   int            quiet_cycles = 0;

   aes_round_primitive_engine uut (.*);

   aes_round_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && (no_idle || $urandom_range(99) >= 35);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [143:0] make_word(input logic [2:0] cmd, input logic [3:0] slot,
                                              input logic [7:0] tidx, input logic [63:0] dh,
                                              input logic [63:0] dl);
      return {1'b0, dl, dh, tidx, slot, cmd};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send(input logic [143:0] w);
      if (!no_idle && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 35);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic set_matrix(input logic [63:0] hi, input logic [63:0] lo);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_MIX_HI;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_MIX_LO;
      csr_wdata <= lo;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++)
         send(make_word(3'($urandom_range(7)), 4'($urandom_range(15)),
                        8'($urandom_range(255)), rand64(), rand64()));
   endtask

   initial begin
      logic [63:0] rh;
      logic [63:0] rl;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // table and keys are partly written here: subbytes and addkey only touch known entries
      send(make_word(CMD_LOAD_STATE, 0, 0, '0, '0));
      send(make_word(CMD_LOAD_TABLE, 0, 8'h00, '0, 64'h63));
      send(make_word(CMD_LOAD_TABLE, 0, 8'hff, '1, '1));
      send(make_word(CMD_SUBBYTES, 0, 0, '0, '0));
      send(make_word(CMD_MIX, 0, 0, '0, '0));
      send(make_word(CMD_LOAD_KEY, 0, 0, '1, '1));
      send(make_word(CMD_LOAD_KEY, 14, 0, rand64(), rand64()));
      send(make_word(CMD_LOAD_KEY, 15, 0, rand64(), rand64()));
      send(make_word(CMD_ADDKEY, 0, 0, '0, '0));
      send(make_word(CMD_ADDKEY, 15, 0, '0, '0));
      send(make_word(CMD_ADDKEY, 14, 0, '0, '0));
      send(make_word(CMD_LOAD_STATE, 0, 0, '1, '1));
      send(make_word(CMD_SHIFT, 0, 0, '0, '0));
      send(make_word(CMD_INVSHIFT, 0, 0, '0, '0));
      send(make_word(CMD_MIX, 0, 0, '0, '0));
      send(make_word(CMD_LOAD_STATE, 0, 0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f));
      send(make_word(CMD_SHIFT, 0, 0, '0, '0));
      send(make_word(CMD_SHIFT, 0, 0, '0, '0));
      send(make_word(CMD_INVSHIFT, 0, 0, '0, '0));
      send(make_word(CMD_MIX, 0, 0, '0, '0));
      send(make_word(CMD_ADDKEY, 14, 0, '0, '0));

      set_matrix('0, '0);
      for (int i = 0; i < 256; i++)
         send(make_word(CMD_LOAD_TABLE, 4'($urandom_range(15)), 8'(i), rand64(), rand64()));
      for (int s = 0; s < KeySlotsDefault; s++)
         send(make_word(CMD_LOAD_KEY, 4'(s), 8'($urandom_range(255)), rand64(), rand64()));
      send_random(90);

      set_matrix('1, '1);
      send_random(90);

      rh = rand64();
      rl = rand64();
      set_matrix(rh, rl);
      no_idle <= 1'b1;
      send_random(90);

      set_matrix(MixHiReset, MixLoReset);
      no_idle <= 1'b0;
      send_random(90);

      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// File: files.f
sv/arpe_pkg.sv
sv/arpe_front.sv
sv/arpe_back.sv
sv/aes_round_primitive_engine.sv
bench/aes_round_checker.sv
bench/tb.sv
